[hdl/sfss_pkg.sv]
// ----------------------------------------------------------------------------
// sfss_pkg: shared constants of the state-feedback steering servo
// Register indexes, pulse limits and fixed-point constants (Q.12).
// ----------------------------------------------------------------------------
package sfss_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_DAMPING    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WHEELBASE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RACE_SLOPE = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RACE_OFFS  = 2'd3;

  localparam logic [14:0] DAMPING_RESET   = 15'd29491;
  localparam logic [9:0]  WHEELBASE_RESET = 10'd265;

  localparam logic [10:0] PULSE_MAX = 11'd1900;
  localparam logic [10:0] PULSE_MIN = 11'd1000;
  localparam logic [10:0] PULSE_MID = 11'd1525;
  localparam int          STRAIGHT_LIMIT = 40;
  localparam int          PULSE_GAIN_Q16 = 52569107;

  localparam logic [2:0] MODE_LABYRINTH = 3'd0;
  localparam logic [2:0] MODE_LANE      = 3'd1;
  localparam logic [2:0] MODE_OVERTAKE  = 3'd2;
  localparam logic [2:0] MODE_SAFETY    = 3'd3;
  localparam logic [2:0] MODE_RACE      = 3'd4;

  localparam logic [1:0] PHASE_START = 2'd0;

  // Q.12 settling distance constants
  localparam logic signed [15:0] Q_0P2   = 16'sd819;
  localparam logic signed [15:0] Q_0P375 = 16'sd1536;
  localparam logic signed [15:0] Q_0P5   = 16'sd2048;
  localparam logic signed [15:0] Q_1P5   = 16'sd6144;
  localparam logic [13:0] Q_0P4 = 14'd1638;
  localparam logic [13:0] Q_0P9 = 14'd3686;
  localparam logic [13:0] Q_1P5U = 14'd6144;
  localparam logic [13:0] Q_2P0 = 14'd8192;
  localparam logic [13:0] Q_3P0 = 14'd12288;

endpackage

[hdl/state_feedback_steering_servo.sv]
// ----------------------------------------------------------------------------
// state_feedback_steering_servo: pole-placement steering to servo pulse
// Settling distance per mode, state-feedback angle, pulse clamp and a
// straight-driving flag over a ring of recent deviations.
// ----------------------------------------------------------------------------
//  channel | ports                                                      | dir
//  in      | in_valid/in_ready, in_drive_mode, in_overtake_phase,       | in
//          | in_speed, in_line_error, in_heading_error                  |
//  out     | out_valid/out_ready, out_servo_pulse, out_driving_straight | out
//  cfg     | cfg_we, cfg_addr, cfg_wdata                                | in
//
//  Moving request: three 64-step divisions in the shared restoring divider
//  plus the multiply steps on the shared multiplier lie between acceptance
//  and the result. Zero speed skips the divisions via S_HOLD; idle modes go
//  straight to S_EMIT, which waits while an unread result holds the output.
//  in_ready is high only while the sequencer waits for a request; a finished
//  result sits in the output register and a new request can start meanwhile.
//  Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module state_feedback_steering_servo #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_drive_mode,
  input  logic [1:0]                          in_overtake_phase,
  input  logic signed [15:0]                  in_speed,
  input  logic signed [15:0]                  in_line_error,
  input  logic signed [15:0]                  in_heading_error,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [10:0]                         out_servo_pulse,
  output logic                                out_driving_straight,
  input  logic                                cfg_we,
  input  logic [sfss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sfss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int REM_W  = 44;
  localparam int DVS_W  = 42;

  typedef enum logic [4:0] {
    S_IDLE, S_DIST, S_CLAMP, S_M1, S_M2, S_M3, S_M4, S_M5, S_DIV, S_M6,
    S_M7, S_M8, S_PHI, S_M9, S_DEV, S_HOLD, S_FLAG, S_EMIT
  } state_t;

  typedef enum logic [1:0] {DV_A, DV_T1, DV_T2} div_id_t;

  state_t  state_r;
  div_id_t div_id_r;

  // configuration
  logic [14:0]        damp_r;
  logic [9:0]         wheel_r;
  logic signed [15:0] race_slope_r, race_offs_r;

  // request
  logic [2:0]         mode_r;
  logic [1:0]         phase_r;
  logic signed [15:0] v_r, e_r, h_r;

  // datapath
  logic signed [32:0] acc_r;
  logic [13:0]        d12_r;
  logic signed [27:0] e1000_r, wh_r, a_r;
  logic signed [42:0] n_r;
  logic [27:0]        sq_r;
  logic signed [53:0] t1_r;
  logic signed [39:0] num2_r;
  logic signed [20:0] t2_r;
  logic signed [15:0] phi_r;
  logic [40:0]        mag_r;

  // divider
  logic [63:0]        dvd_r;
  logic [REM_W-1:0]   rem_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [5:0]         cnt_r;
  logic               neg_r;

  // state
  logic [10:0]        held_r;
  logic signed [15:0] hist_r [HISTORY_DEPTH];
  logic [SLOT_W-1:0]  slot_r;
  logic               flag_r;

  logic               out_valid_r;
  logic [10:0]        out_pulse_r;
  logic               out_flag_r;

  // mode table
  logic signed [15:0] sel_slope, sel_offs;
  logic [13:0]        sel_lo, sel_hi;

  always_comb begin
    sel_slope = race_slope_r;
    sel_offs  = race_offs_r;
    sel_lo    = sfss_pkg::Q_0P9;
    sel_hi    = sfss_pkg::Q_1P5U;
    priority if (mode_r == sfss_pkg::MODE_LABYRINTH) begin
      sel_slope = sfss_pkg::Q_0P5;   sel_offs = sfss_pkg::Q_0P375;
      sel_lo    = sfss_pkg::Q_0P9;   sel_hi   = sfss_pkg::Q_2P0;
    end else if (mode_r == sfss_pkg::MODE_LANE || mode_r == sfss_pkg::MODE_SAFETY) begin
      sel_slope = sfss_pkg::Q_0P375; sel_offs = sfss_pkg::Q_0P375;
      sel_lo    = sfss_pkg::Q_0P9;   sel_hi   = sfss_pkg::Q_2P0;
    end else if (mode_r == sfss_pkg::MODE_OVERTAKE && phase_r == sfss_pkg::PHASE_START) begin
      sel_slope = sfss_pkg::Q_0P2;   sel_offs = sfss_pkg::Q_0P2;
      sel_lo    = sfss_pkg::Q_0P4;   sel_hi   = sfss_pkg::Q_3P0;
    end else if (mode_r == sfss_pkg::MODE_OVERTAKE) begin
      sel_slope = sfss_pkg::Q_0P5;   sel_offs = sfss_pkg::Q_1P5;
      sel_lo    = sfss_pkg::Q_1P5U;  sel_hi   = sfss_pkg::Q_3P0;
    end else begin
      sel_slope = race_slope_r;      sel_offs = race_offs_r;
      sel_lo    = sfss_pkg::Q_0P9;   sel_hi   = sfss_pkg::Q_1P5U;
    end
  end

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [13:0]        w9;
  logic [14:0]        k_eff;
  logic signed [27:0] diff;

  assign w9    = {1'b0, wheel_r, 3'b000} + {4'b0000, wheel_r};
  assign k_eff = (damp_r == '0) ? 15'd1 : damp_r;
  assign diff  = e1000_r - wh_r;

  // magnitudes
  logic [42:0] n_abs;
  logic [27:0] a_abs;
  logic [39:0] num2_abs;
  logic [15:0] phi_abs;

  assign n_abs    = n_r[42] ? 43'(-n_r) : 43'(n_r);
  assign a_abs    = a_r[27] ? 28'(-a_r) : 28'(a_r);
  assign num2_abs = num2_r[39] ? 40'(-num2_r) : 40'(num2_r);
  assign phi_abs  = phi_r[15] ? 16'(-phi_r) : 16'(phi_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_DIST: begin mul_a = 33'(sel_slope); mul_b = 33'(v_r); end
      S_M1:   begin mul_a = 33'(e_r); mul_b = 33'(1000); end
      S_M2:   begin mul_a = 33'(h_r); mul_b = $signed({23'b0, wheel_r}); end
      S_M3:   begin mul_a = 33'(diff); mul_b = $signed({19'b0, w9}); end
      S_M4:   begin mul_a = $signed({19'b0, d12_r}); mul_b = $signed({19'b0, d12_r}); end
      S_M5:   begin mul_a = $signed({5'b0, sq_r}); mul_b = 33'(15625); end
      S_M6:   begin mul_a = $signed({18'b0, k_eff}); mul_b = $signed({18'b0, k_eff}); end
      S_M7:   begin mul_a = 33'(wh_r); mul_b = 33'(3072); end
      S_M8:   begin mul_a = $signed({19'b0, d12_r}); mul_b = 33'(125); end
      S_M9:   begin
        mul_a = $signed({17'b0, phi_abs});
        mul_b = 33'(sfss_pkg::PULSE_GAIN_Q16);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider step
  logic [REM_W-1:0] rem_sh, rem_nxt;
  logic             div_ge;
  logic [63:0]      dvd_nxt;

  assign rem_sh  = {rem_r[REM_W-2:0], dvd_r[63]};
  assign div_ge  = rem_sh >= {2'b00, dvs_r};
  assign rem_nxt = div_ge ? rem_sh - {2'b00, dvs_r} : rem_sh;
  assign dvd_nxt = {dvd_r[62:0], div_ge};

  // settling distance clamp
  logic signed [33:0] d24;
  logic signed [21:0] dq, lo_s, hi_s;

  assign d24  = 34'(acc_r) + (34'(sel_offs) <<< 12);
  assign dq   = 22'(d24 >>> 12);
  assign lo_s = $signed({8'b0, sel_lo});
  assign hi_s = $signed({8'b0, sel_hi});

  // angle sum and clamp
  logic signed [54:0] phi_sum;
  assign phi_sum = 55'(t1_r) + 55'(t2_r);

  // rounding and pulse
  logic [40:0]        rnd;
  logic signed [15:0] dev_mov, dev_hold, dev_w;
  logic signed [16:0] pulse_raw;
  logic [10:0]        pulse_clamped;

  assign rnd       = mag_r + 41'd134217728;
  assign dev_mov   = phi_r[15] ? -$signed({3'b000, rnd[40:28]}) : $signed({3'b000, rnd[40:28]});
  assign dev_hold  = $signed({5'b0, held_r}) - $signed({5'b0, sfss_pkg::PULSE_MID});
  assign dev_w     = (state_r == S_DEV) ? dev_mov : dev_hold;
  assign pulse_raw = 17'(dev_mov) + $signed({6'b0, sfss_pkg::PULSE_MID});

  always_comb begin
    if (pulse_raw < $signed({6'b0, sfss_pkg::PULSE_MIN}))
      pulse_clamped = sfss_pkg::PULSE_MIN;
    else if (pulse_raw > $signed({6'b0, sfss_pkg::PULSE_MAX}))
      pulse_clamped = sfss_pkg::PULSE_MAX;
    else
      pulse_clamped = pulse_raw[10:0];
  end

  logic all_small;
  always_comb begin
    all_small = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist_r[i] > 16'sd40 || hist_r[i] < -16'sd40) all_small = 1'b0;
    end
  end

  logic [SLOT_W-1:0] slot_nxt;
  assign slot_nxt = (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_id_r     <= DV_A;
      damp_r       <= sfss_pkg::DAMPING_RESET;
      wheel_r      <= sfss_pkg::WHEELBASE_RESET;
      race_slope_r <= '0;
      race_offs_r  <= '0;
      held_r       <= sfss_pkg::PULSE_MID;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_r[i] <= '0;
      slot_r       <= '0;
      flag_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          sfss_pkg::CFG_DAMPING:    damp_r       <= cfg_wdata[14:0];
          sfss_pkg::CFG_WHEELBASE:  wheel_r      <= cfg_wdata[9:0];
          sfss_pkg::CFG_RACE_SLOPE: race_slope_r <= $signed(cfg_wdata);
          sfss_pkg::CFG_RACE_OFFS:  race_offs_r  <= $signed(cfg_wdata);
          default: ;
        endcase
      end

      // S_EMIT owns out_valid_r in its own cycle
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_drive_mode;
            phase_r <= in_overtake_phase;
            v_r     <= in_speed;
            e_r     <= in_line_error;
            h_r     <= in_heading_error;
            state_r <= (in_drive_mode > sfss_pkg::MODE_RACE) ? S_EMIT : S_DIST;
          end
        end
        S_DIST: begin
          acc_r   <= mul_p[32:0];
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          if (dq < lo_s)      d12_r <= sel_lo;
          else if (dq > hi_s) d12_r <= sel_hi;
          else                d12_r <= dq[13:0];
          state_r <= (v_r == '0) ? S_HOLD : S_M1;
        end
        S_M1: begin e1000_r <= mul_p[27:0]; state_r <= S_M2; end
        S_M2: begin wh_r    <= mul_p[27:0]; state_r <= S_M3; end
        S_M3: begin n_r     <= mul_p[42:0]; state_r <= S_M4; end
        S_M4: begin sq_r    <= mul_p[27:0]; state_r <= S_M5; end
        S_M5: begin
          dvs_r    <= mul_p[41:0];
          dvd_r    <= {22'b0, n_abs[41:0]} << 22;
          neg_r    <= n_r[42];
          rem_r    <= '0;
          cnt_r    <= '0;
          div_id_r <= DV_A;
          state_r  <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) begin
            unique case (div_id_r)
              DV_A: begin
                a_r     <= neg_r ? -$signed(dvd_nxt[27:0]) : $signed(dvd_nxt[27:0]);
                state_r <= S_M6;
              end
              DV_T1: begin
                t1_r    <= neg_r ? -$signed(dvd_nxt[53:0]) : $signed(dvd_nxt[53:0]);
                state_r <= S_M7;
              end
              DV_T2: begin
                t2_r    <= neg_r ? -$signed(dvd_nxt[20:0]) : $signed(dvd_nxt[20:0]);
                state_r <= S_PHI;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_M6: begin
          dvs_r    <= mul_p[41:0];
          dvd_r    <= {36'b0, a_abs} << 26;
          neg_r    <= a_r[27];
          rem_r    <= '0;
          cnt_r    <= '0;
          div_id_r <= DV_T1;
          state_r  <= S_DIV;
        end
        S_M7: begin num2_r <= mul_p[39:0]; state_r <= S_M8; end
        S_M8: begin
          dvs_r    <= mul_p[41:0];
          dvd_r    <= {24'b0, num2_abs};
          neg_r    <= num2_r[39];
          rem_r    <= '0;
          cnt_r    <= '0;
          div_id_r <= DV_T2;
          state_r  <= S_DIV;
        end
        S_PHI: begin
          if (phi_sum > 55'sd32767)       phi_r <= 16'sd32767;
          else if (phi_sum < -55'sd32767) phi_r <= -16'sd32767;
          else                            phi_r <= phi_sum[15:0];
          state_r <= S_M9;
        end
        S_M9: begin mag_r <= mul_p[40:0]; state_r <= S_DEV; end
        S_DEV: begin
          held_r         <= pulse_clamped;
          hist_r[slot_r] <= dev_w;
          slot_r         <= slot_nxt;
          state_r        <= S_FLAG;
        end
        S_HOLD: begin
          hist_r[slot_r] <= dev_w;
          slot_r         <= slot_nxt;
          state_r        <= S_FLAG;
        end
        S_FLAG: begin
          flag_r  <= all_small;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_pulse_r <= held_r;
            out_flag_r  <= flag_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_servo_pulse      = out_pulse_r;
  assign out_driving_straight = out_flag_r;

`ifndef SYNTH
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r >= sfss_pkg::PULSE_MIN && held_r <= sfss_pkg::PULSE_MAX)
    else $error("held pulse out of range");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pulse_r >= sfss_pkg::PULSE_MIN && out_pulse_r <= sfss_pkg::PULSE_MAX))
    else $error("result pulse out of range");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slot_r) < HISTORY_DEPTH)
    else $error("history slot past depth");

  a_dist_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M1) |-> (d12_r >= sfss_pkg::Q_0P4))
    else $error("settling distance below floor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dvs_r != '0))
    else $error("divide by zero");
`endif

endmodule
